// ===== rtl/core/tdss_pkg.sv =====
// Shared types and constants for the three-digit seven-segment scanner.
// Holds the digit record, scan phase encoding, register indexes and segment table.
// No dependencies.
`default_nettype none

package tdss_pkg;

    localparam int VALUE_W     = 10;
    localparam int DWELL_W     = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic       CFG_ANODE_MODE   = 1'b0;
    localparam logic       CFG_DWELL_TICKS  = 1'b1;

    localparam logic [7:0] BLANK_PATTERN    = 8'hFF;
    localparam logic [7:0] DARK_PATTERN     = 8'h00;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } digits_t;

    typedef enum logic [1:0] {
        PH_LATCH_LOW  = 2'd0,
        PH_SHIFT      = 2'd1,
        PH_LATCH_HIGH = 2'd2,
        PH_DWELL      = 2'd3
    } phase_t;

    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit) inside
            4'd0, 4'd10: seg = 8'b11000000;
            4'd1, 4'd11: seg = 8'b11111001;
            4'd2, 4'd12: seg = 8'b10100100;
            4'd3, 4'd13: seg = 8'b10110000;
            4'd4, 4'd14: seg = 8'b10011001;
            4'd5, 4'd15: seg = 8'b10010010;
            4'd6:        seg = 8'b10000010;
            4'd7:        seg = 8'b11111000;
            4'd8:        seg = 8'b10000000;
            4'd9:        seg = 8'b10010000;
            default:     seg = BLANK_PATTERN;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/three_digit_seven_segment_scanner_top.sv =====
// Top level of the three-digit seven-segment scanner for a 74HC595 display.
// Instantiates tdss_front, tdss_queue and tdss_back; uses tdss_pkg.
//
// Usage:
//   Each input beat on in_valid/in_stall is one scan tick carrying display_value.
//   Each tick yields exactly one output beat on out_valid/out_stall with the
//   serial_data, shift_clock and latch_clock line levels and the digit_drive pins
//   after that tick. The value is taken on the first tick of the ones slot only,
//   saturated to 999 and split into digits; leading zeros are blank.
//   One slot is 1 latch-low tick, 16 shift ticks, 1 latch-high tick and
//   dwell_ticks lit ticks (0 acts as 1).
//   Throughput: one beat per cycle while out_stall is low, set by the single-step
//   scan sequencer. Path: from input beat to output beat through the front register,
//   the queue and the sequencer output register when nothing stalls.
//   Configuration: cfg_write with cfg_index 0 sets the anode mode (1 = common
//   anode), index 1 sets dwell_ticks; write only while the block is idle.
//   Reset: scan restarts at the ones slot, lines low, anode mode 1, dwell 5000.
//   Stall: out_stall holds the output beat; the queue fills and in_stall rises.
`default_nettype none

module three_digit_seven_segment_scanner_top #(
    parameter int NUM_DIGITS = 3
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic                         cfg_index,
    input  wire logic [tdss_pkg::DWELL_W-1:0] cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [tdss_pkg::VALUE_W-1:0] display_value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              serial_data,
    output logic                              shift_clock,
    output logic                              latch_clock,
    output logic [2:0]                        digit_drive
);

    logic                          anode_mode_reg;
    logic [tdss_pkg::DWELL_W-1:0]  dwell_ticks_reg;
    logic                          push_valid;
    logic                          push_ready;
    tdss_pkg::digits_t             push_data;
    logic                          pop_valid;
    logic                          pop_ready;
    tdss_pkg::digits_t             pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anode_mode_reg   <= 1'b1;
            dwell_ticks_reg  <= 16'd5000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tdss_pkg::CFG_ANODE_MODE:   anode_mode_reg   <= cfg_data[0];
                tdss_pkg::CFG_DWELL_TICKS:  dwell_ticks_reg  <= cfg_data;
                default:                    ;
            endcase
        end
    end

    tdss_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .display_value (display_value),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    tdss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tdss_back #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .anode_mode   (anode_mode_reg),
        .dwell_ticks  (dwell_ticks_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .serial_data  (serial_data),
        .shift_clock  (shift_clock),
        .latch_clock  (latch_clock),
        .digit_drive  (digit_drive)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tdss_front.sv =====
// Front end: accepts tick beats, saturates the value and splits it into digits.
// Uses tdss_pkg for the digit record; feeds tdss_queue.
`default_nettype none

module tdss_front #(
    parameter int NUM_DIGITS = 3
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [tdss_pkg::VALUE_W-1:0] display_value,
    output logic                              push_valid,
    input  wire logic                         push_ready,
    output tdss_pkg::digits_t                 push_data
);

    localparam logic [tdss_pkg::VALUE_W-1:0] LIMIT =
        (NUM_DIGITS >= 3) ? 10'd999 : ((NUM_DIGITS == 2) ? 10'd99 : 10'd9);

    logic                              front_valid_reg;
    logic                              front_valid_next;
    tdss_pkg::digits_t                 front_data_reg;
    tdss_pkg::digits_t                 split_digits;
    logic                              accept;
    logic [tdss_pkg::VALUE_W-1:0]      sat_value;
    logic [15:0]                       hund_prod;
    logic [9:0]                        rem_wide;
    logic [6:0]                        rem;
    logic [14:0]                       tens_prod;
    logic [6:0]                        ones_wide;

    assign in_stall   = front_valid_reg && !push_ready;
    assign accept     = in_valid && !in_stall;
    assign push_valid = front_valid_reg;
    assign push_data  = front_data_reg;

    always_comb
    begin
        sat_value             = (display_value > LIMIT) ? LIMIT : display_value;
        hund_prod             = 16'(sat_value) * 16'd41;
        split_digits.hundreds = hund_prod[15:12];
        rem_wide              = sat_value - 10'(split_digits.hundreds) * 10'd100;
        rem                   = rem_wide[6:0];
        tens_prod             = 15'(rem) * 15'd205;
        split_digits.tens     = tens_prod[14:11];
        ones_wide             = rem - 7'(split_digits.tens) * 7'd10;
        split_digits.ones     = ones_wide[3:0];
    end

    assign front_valid_next = accept || (front_valid_reg && !push_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_data_reg <= split_digits;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tdss_queue.sv =====
// Short queue between the front end and the scan sequencer.
// Uses tdss_pkg for the digit record and queue depth.
`default_nettype none

module tdss_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  wire tdss_pkg::digits_t push_data,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output tdss_pkg::digits_t pop_data
);

    localparam int AW = tdss_pkg::QUEUE_AW;
    localparam int CW = AW + 1;

    tdss_pkg::digits_t   entry_reg [tdss_pkg::QUEUE_DEPTH];
    logic [AW-1:0]       wr_ptr_reg;
    logic [AW-1:0]       wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg;
    logic [AW-1:0]       rd_ptr_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CW'(tdss_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(tdss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(tdss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tdss_back.sv =====
// Scan sequencer: one pin phase per beat, drives the 74HC595 lines and digit pins.
// Uses tdss_pkg for phases, digit record and segment table; fed by tdss_queue.
`default_nettype none

module tdss_back #(
    parameter int NUM_DIGITS = 3
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire tdss_pkg::digits_t            pop_data,
    input  wire logic                         anode_mode,
    input  wire logic [tdss_pkg::DWELL_W-1:0] dwell_ticks,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              serial_data,
    output logic                              shift_clock,
    output logic                              latch_clock,
    output logic [2:0]                        digit_drive
);

    localparam int SLOT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int DW     = tdss_pkg::DWELL_W;

    tdss_pkg::phase_t    phase_reg;
    tdss_pkg::phase_t    phase_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [2:0]          bit_pos_reg;
    logic [2:0]          bit_pos_next;
    logic                clock_half_reg;
    logic                clock_half_next;
    logic [DW-1:0]       dwell_count_reg;
    logic [DW-1:0]       dwell_count_next;
    tdss_pkg::digits_t   held_reg;
    tdss_pkg::digits_t   held_next;
    logic [7:0]          pattern_reg;
    logic [7:0]          pattern_next;
    logic                data_reg;
    logic                data_next;
    logic                clock_reg;
    logic                clock_next;
    logic                latch_reg;
    logic                latch_next;
    logic [2:0]          drive_reg;
    logic [2:0]          drive_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic                advance;
    logic                sample;
    tdss_pkg::digits_t   view;
    logic                shown;
    logic [3:0]          slot_digit;
    logic [2:0]          slot_hot;
    logic [2:0]          off_levels;
    logic [DW-1:0]       dwell_eff;
    logic [DW:0]         dwell_inc;
    logic                dwell_done;
    logic [7:0]          seg;

    assign pop_ready = !out_valid_reg || !out_stall;
    assign advance   = pop_valid && pop_ready;
    assign sample    = (phase_reg == tdss_pkg::PH_LATCH_LOW) && (slot_reg == '0);
    assign view      = sample ? pop_data : held_reg;
    assign off_levels = anode_mode ? 3'b000 : 3'b111;
    assign dwell_eff  = (dwell_ticks == '0) ? DW'(1) : dwell_ticks;
    assign dwell_inc  = {1'b0, dwell_count_reg} + 1'b1;
    assign dwell_done = (dwell_inc >= {1'b0, dwell_eff});
    assign seg        = tdss_pkg::seg_pattern(slot_digit);

    always_comb
    begin
        shown      = 1'b0;
        slot_digit = view.ones;
        if (slot_reg == '0)
        begin
            shown      = 1'b1;
            slot_digit = view.ones;
        end
        else if ((NUM_DIGITS >= 2) && (slot_reg == SLOT_W'(1)))
        begin
            shown      = (view.tens != '0) || (view.hundreds != '0);
            slot_digit = view.tens;
        end
        else if ((NUM_DIGITS >= 3) && (slot_reg == SLOT_W'(2)))
        begin
            shown      = (view.hundreds != '0);
            slot_digit = view.hundreds;
        end
        for (int i = 0; i < 3; i++)
        begin
            slot_hot[i] = (i < NUM_DIGITS) && (slot_reg == SLOT_W'(i));
        end
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        slot_next        = slot_reg;
        bit_pos_next     = bit_pos_reg;
        clock_half_next  = clock_half_reg;
        dwell_count_next = dwell_count_reg;
        held_next        = held_reg;
        pattern_next     = pattern_reg;
        if (advance)
        begin
            unique case (phase_reg)
                tdss_pkg::PH_LATCH_LOW:
                begin
                    if (sample)
                    begin
                        held_next = pop_data;
                    end
                    if (shown)
                    begin
                        pattern_next = anode_mode ? seg : ~seg;
                    end
                    else
                    begin
                        pattern_next = anode_mode ? tdss_pkg::BLANK_PATTERN
                                                  : tdss_pkg::DARK_PATTERN;
                    end
                    bit_pos_next    = 3'd7;
                    clock_half_next = 1'b0;
                    phase_next      = tdss_pkg::PH_SHIFT;
                end
                tdss_pkg::PH_SHIFT:
                begin
                    clock_half_next = !clock_half_reg;
                    if (clock_half_reg)
                    begin
                        if (bit_pos_reg == '0)
                        begin
                            phase_next = tdss_pkg::PH_LATCH_HIGH;
                        end
                        else
                        begin
                            bit_pos_next = bit_pos_reg - 1'b1;
                        end
                    end
                end
                tdss_pkg::PH_LATCH_HIGH:
                begin
                    dwell_count_next = '0;
                    phase_next       = tdss_pkg::PH_DWELL;
                end
                tdss_pkg::PH_DWELL:
                begin
                    dwell_count_next = dwell_inc[DW-1:0];
                    if (dwell_done)
                    begin
                        dwell_count_next = '0;
                        slot_next        = (slot_reg == SLOT_W'(NUM_DIGITS - 1)) ? '0
                                                                                 : slot_reg + 1'b1;
                        phase_next       = tdss_pkg::PH_LATCH_LOW;
                    end
                end
            endcase
        end
    end

    // line levels
    always_comb
    begin
        data_next      = data_reg;
        clock_next     = clock_reg;
        latch_next     = latch_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
            drive_next     = off_levels;
            unique case (phase_reg)
                tdss_pkg::PH_LATCH_LOW:
                begin
                    latch_next = 1'b0;
                end
                tdss_pkg::PH_SHIFT:
                begin
                    if (!clock_half_reg)
                    begin
                        data_next  = pattern_reg[bit_pos_reg];
                        clock_next = 1'b1;
                    end
                    else
                    begin
                        clock_next = 1'b0;
                    end
                end
                tdss_pkg::PH_LATCH_HIGH:
                begin
                    latch_next = 1'b1;
                end
                tdss_pkg::PH_DWELL:
                begin
                    if (shown)
                    begin
                        drive_next = off_levels ^ slot_hot;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= tdss_pkg::PH_LATCH_LOW;
            slot_reg        <= '0;
            bit_pos_reg     <= 3'd7;
            clock_half_reg  <= 1'b0;
            dwell_count_reg <= '0;
            held_reg        <= '0;
            pattern_reg     <= tdss_pkg::BLANK_PATTERN;
            data_reg        <= 1'b0;
            clock_reg       <= 1'b0;
            latch_reg       <= 1'b0;
            drive_reg       <= 3'b000;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            slot_reg        <= slot_next;
            bit_pos_reg     <= bit_pos_next;
            clock_half_reg  <= clock_half_next;
            dwell_count_reg <= dwell_count_next;
            held_reg        <= held_next;
            pattern_reg     <= pattern_next;
            data_reg        <= data_next;
            clock_reg       <= clock_next;
            latch_reg       <= latch_next;
            drive_reg       <= drive_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign serial_data = data_reg;
    assign shift_clock = clock_reg;
    assign latch_clock = latch_reg;
    assign digit_drive = drive_reg;

endmodule

`default_nettype wire

// ===== rtl/core/tdss_checker.sv =====
// Port-level checker for the scanner top level, attached by bind.
// Depends on the top level's port list only.
`default_nettype none

module tdss_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       serial_data,
    input wire logic       shift_clock,
    input wire logic       latch_clock,
    input wire logic [2:0] digit_drive
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(shift_clock && latch_clock))
        else $error("shift clock and latch high together");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(digit_drive) <= 1 || $countones(~digit_drive) <= 1))
        else $error("more than one digit lit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && digit_drive != 3'b000 && digit_drive != 3'b111)
            |-> (latch_clock && !shift_clock))
        else $error("digit lit outside the dwell phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(serial_data)
            && $stable(shift_clock) && $stable(latch_clock) && $stable(digit_drive)))
        else $error("stalled output beat changed");

endmodule

bind three_digit_seven_segment_scanner_top tdss_checker u_checker (.*);

`default_nettype wire

// ===== dv/tb_three_digit_seven_segment_scanner_top.sv =====
// Self-checking testbench for the three-digit seven-segment scanner top level.
// Drives scan ticks through the valid/stall channels and checks every line-level beat
// against an in-bench scan predictor; depends on tdss_pkg and the scanner RTL.
module tb_three_digit_seven_segment_scanner_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 300;
    localparam logic [79:0] GLYPHS = {
        8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };
    localparam int NUM_SHOWCASE = 18;
    localparam logic [179:0] SHOWCASE = {
        10'd0,   10'd999, 10'd1000, 10'd1023, 10'd5,  10'd40,
        10'd100, 10'd7,   10'd12,   10'd305,  10'd468, 10'd890,
        10'd10,  10'd99,  10'd512,  10'd254,  10'd671, 10'd123
    };

    typedef struct packed {
        logic       data;
        logic       sclk;
        logic       latch;
        logic [2:0] digits;
    } lines_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic                         cfg_index = tdss_pkg::CFG_ANODE_MODE;
    logic [tdss_pkg::DWELL_W-1:0] cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [tdss_pkg::VALUE_W-1:0] display_value = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic                         serial_data;
    logic                         shift_clock;
    logic                         latch_clock;
    logic [2:0]                   digit_drive;

    three_digit_seven_segment_scanner_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .display_value(display_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .serial_data  (serial_data),
        .shift_clock  (shift_clock),
        .latch_clock  (latch_clock),
        .digit_drive  (digit_drive)
    );

    // scan predictor state
    logic                         anode_mode = 1'b1;
    logic [tdss_pkg::DWELL_W-1:0] dwell_setting = 16'd5000;
    int                           scan_slot = 0;
    tdss_pkg::phase_t             scan_phase = tdss_pkg::PH_LATCH_LOW;
    int                           bit_index = 7;
    logic                         clock_high = 1'b0;
    int                           dwell_elapsed = 0;
    logic [3:0]                   held_digit [3] = '{4'd0, 4'd0, 4'd0};
    logic [7:0]                   segment_bits = tdss_pkg::BLANK_PATTERN;
    lines_t                       line_state = '0;

    logic [tdss_pkg::VALUE_W-1:0] pending_values [$];
    lines_t                       expected_lines [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int tx_wait = 0;
    int rx_wait = 0;
    int hold_left = 0;
    int next_hold_at = 1200;
    logic long_hold = 1'b0;
    int results_seen = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    lines_t got_lines;
    lines_t want_lines;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(0, 19);
        return 0;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 25;
            default: return 100;
        endcase
    endfunction

    function automatic logic [tdss_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0, 1: return tdss_pkg::VALUE_W'($urandom_range(1000, 1023));
            2: return tdss_pkg::VALUE_W'($urandom_range(0, 9));
            3: return tdss_pkg::VALUE_W'($urandom_range(10, 99));
            default: return tdss_pkg::VALUE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic bit slot_lit(int k);
        case (k)
            0: return 1'b1;
            1: return held_digit[1] != 0 || held_digit[2] != 0;
            default: return held_digit[2] != 0;
        endcase
    endfunction

    task automatic advance_scan(input logic [tdss_pkg::VALUE_W-1:0] raw);
        int     v;
        int     dwell_limit;
        logic   [2:0] off_level;
        lines_t result;
        logic   [7:0] glyph;
        off_level = anode_mode ? 3'b000 : 3'b111;
        result.digits = off_level;
        dwell_limit = (dwell_setting == 0) ? 1 : int'(dwell_setting);
        case (scan_phase)
            tdss_pkg::PH_LATCH_LOW:
            begin
                if (scan_slot == 0)
                begin
                    v = (raw > 999) ? 999 : int'(raw);
                    held_digit[0] = 4'(v % 10);
                    held_digit[1] = 4'((v / 10) % 10);
                    held_digit[2] = 4'(v / 100);
                end
                line_state.latch = 1'b0;
                if (slot_lit(scan_slot))
                begin
                    glyph = GLYPHS[held_digit[scan_slot] * 8 +: 8];
                    segment_bits = anode_mode ? glyph : ~glyph;
                end
                else
                begin
                    segment_bits = anode_mode ? tdss_pkg::BLANK_PATTERN
                                              : tdss_pkg::DARK_PATTERN;
                end
                bit_index = 7;
                clock_high = 1'b0;
                scan_phase = tdss_pkg::PH_SHIFT;
            end
            tdss_pkg::PH_SHIFT:
            begin
                if (!clock_high)
                begin
                    line_state.data = segment_bits[bit_index];
                    line_state.sclk = 1'b1;
                    clock_high = 1'b1;
                end
                else
                begin
                    line_state.sclk = 1'b0;
                    clock_high = 1'b0;
                    if (bit_index == 0)
                        scan_phase = tdss_pkg::PH_LATCH_HIGH;
                    else
                        bit_index--;
                end
            end
            tdss_pkg::PH_LATCH_HIGH:
            begin
                line_state.latch = 1'b1;
                dwell_elapsed = 0;
                scan_phase = tdss_pkg::PH_DWELL;
            end
            default:
            begin
                if (slot_lit(scan_slot))
                    result.digits = off_level ^ (3'b001 << scan_slot);
                dwell_elapsed++;
                if (dwell_elapsed >= dwell_limit)
                begin
                    dwell_elapsed = 0;
                    scan_slot = (scan_slot == 2) ? 0 : scan_slot + 1;
                    scan_phase = tdss_pkg::PH_LATCH_LOW;
                end
            end
        endcase
        result.data = line_state.data;
        result.sclk = line_state.sclk;
        result.latch = line_state.latch;
        expected_lines.push_back(result);
    endtask

    // driver: hold a stalled beat, advance on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                advance_scan(display_value);
                tx_wait = draw_wait(tx_idle_pct);
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_values.size() > 0)
                begin
                    in_valid <= 1'b1;
                    display_value <= pending_values.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void note_mismatch(string field, int want, int got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // long receiver hold, started once enough beats have been seen
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (results_seen >= next_hold_at)
            begin
                hold_left = LONG_HOLD;
                next_hold_at += 1300;
            end
            long_hold <= (hold_left > 0);
        end
    end

    // monitor: compare each beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got_lines = '{serial_data, shift_clock, latch_clock, digit_drive};
                if (expected_lines.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected beat, expected none, actual %h",
                             $time, got_lines);
                end
                else
                begin
                    want_lines = expected_lines.pop_front();
                    if (got_lines.data !== want_lines.data)
                        note_mismatch("serial_data", want_lines.data, got_lines.data);
                    if (got_lines.sclk !== want_lines.sclk)
                        note_mismatch("shift_clock", want_lines.sclk, got_lines.sclk);
                    if (got_lines.latch !== want_lines.latch)
                        note_mismatch("latch_clock", want_lines.latch, got_lines.latch);
                    if (got_lines.digits !== want_lines.digits)
                        note_mismatch("digit_drive", want_lines.digits, got_lines.digits);
                end
                results_seen++;
                rx_wait = draw_wait(rx_idle_pct);
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
            end
            out_stall <= long_hold || (rx_wait > 0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_three_digit_seven_segment_scanner_top failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_values.size() != 0 || in_valid || expected_lines.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [tdss_pkg::DWELL_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        if (idx == tdss_pkg::CFG_ANODE_MODE)
            anode_mode = value[0];
        else
            dwell_setting = value;
    endtask

    task automatic run_phase(input logic anode, input int dwell, input int count,
                             input bit quiet, input bit pause_midway);
        wait_drained();
        tx_idle_pct = quiet ? 0 : pick_pct();
        rx_idle_pct = quiet ? 0 : pick_pct();
        write_reg(tdss_pkg::CFG_ANODE_MODE, tdss_pkg::DWELL_W'(anode));
        write_reg(tdss_pkg::CFG_DWELL_TICKS, tdss_pkg::DWELL_W'(dwell));
        for (int k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
                wait_drained();
            pending_values.push_back(random_value());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: common anode, long dwell
        for (int k = 0; k < 60; k++)
            pending_values.push_back(random_value());

        // one full scan per showcase value at the shortest dwell
        wait_drained();
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        write_reg(tdss_pkg::CFG_DWELL_TICKS, tdss_pkg::DWELL_W'(1));
        for (int i = 0; i < NUM_SHOWCASE; i++)
            for (int k = 0; k < 3 * (18 + 1); k++)
                pending_values.push_back(SHOWCASE[i * tdss_pkg::VALUE_W +: tdss_pkg::VALUE_W]);

        run_phase(1'b0, 1,     130, 1'b1, 1'b0);
        run_phase(1'b1, 2,     130, 1'b0, 1'b0);
        run_phase(1'b0, 0,     110, 1'b0, 1'b1);
        run_phase(1'b1, 3,     130, 1'b0, 1'b0);
        run_phase(1'b0, 7,     110, 1'b0, 1'b0);
        run_phase(1'b1, 65535, 70,  1'b0, 1'b0);
        run_phase(1'b0, 40,    90,  1'b0, 1'b0);
        run_phase(1'b1, 1,     90,  1'b0, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_lines.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("tb_three_digit_seven_segment_scanner_top passed");
        else
            $display("tb_three_digit_seven_segment_scanner_top failed");
        $finish;
    end
endmodule
